[src/sdv_pkg.sv]
package sdv_pkg;

  localparam int SECTION_TYPES        = 7;
  localparam int WORDS_PER_DESCRIPTOR = 5;
  localparam int MAX_DESCRIPTOR_WORDS = 4096;
  localparam int MAX_DESCRIPTORS      = MAX_DESCRIPTOR_WORDS / WORDS_PER_DESCRIPTOR;
  localparam int REM_W                = $clog2(MAX_DESCRIPTORS + 1);

  localparam int RANGE_DEPTH = 7;
  localparam int RANGE_AW    = $clog2(RANGE_DEPTH);
  localparam int RC_W        = $clog2(RANGE_DEPTH + 1);

  localparam int TYPE_IDX_W = (SECTION_TYPES > 1) ? $clog2(SECTION_TYPES) : 1;

  localparam int VER_W    = 8;
  localparam int GEN_W    = 32;
  localparam int WORDS_W  = 13;
  localparam int SIZE_W   = 31;
  localparam int TYPE_W   = 8;
  localparam int WIDE_W   = 32;
  localparam int MASK_W   = 7;
  localparam int ERR_W    = 4;
  localparam int STRIDE_W = 3;
  localparam int PROD_W   = SIZE_W + STRIDE_W;

  // floor(words / WORDS_PER_DESCRIPTOR) as a multiply by a scaled reciprocal
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = (2**RECIP_SHIFT + WORDS_PER_DESCRIPTOR - 1) / WORDS_PER_DESCRIPTOR;
  localparam int HP_W        = WORDS_W + RECIP_SHIFT;

  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_MAJOR      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MINOR      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_GENERATION = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MASK       = 2'd3;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE        = 4'd0,
    ERR_VERSION     = 4'd1,
    ERR_GENERATION  = 4'd2,
    ERR_STRIDE      = 4'd3,
    ERR_DUPLICATE   = 4'd4,
    ERR_UNINSTALLED = 4'd5,
    ERR_OVERRUN     = 4'd6,
    ERR_INT_OVERLAP = 4'd7,
    ERR_FLT_OVERLAP = 4'd8
  } err_code_t;

  typedef struct packed {
    logic [VER_W-1:0]         major;
    logic [VER_W-1:0]         minor;
    logic signed [GEN_W-1:0]  generation;
    logic [MASK_W-1:0]        mask;
  } cfg_t;

  typedef struct packed {
    logic [SIZE_W-1:0] int_start;
    logic [SIZE_W-1:0] int_end;
    logic [SIZE_W-1:0] flt_start;
    logic [SIZE_W-1:0] flt_end;
  } range_entry_t;

  function automatic logic [STRIDE_W-1:0] int_row_step(input logic [TYPE_IDX_W-1:0] t);
    case (t)
      3'd0:    return 3'd4;
      3'd1:    return 3'd3;
      3'd2:    return 3'd3;
      3'd3:    return 3'd3;
      3'd4:    return 3'd5;
      3'd5:    return 3'd4;
      3'd6:    return 3'd4;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [STRIDE_W-1:0] flt_stride(input logic [TYPE_IDX_W-1:0] t);
    case (t)
      3'd0:    return 3'd2;
      3'd1:    return 3'd5;
      3'd2:    return 3'd4;
      3'd3:    return 3'd3;
      3'd4:    return 3'd1;
      3'd5:    return 3'd3;
      3'd6:    return 3'd2;
      default: return 3'd0;
    endcase
  endfunction

endpackage

[src/sdv_ifs.sv]
interface sdv_in_if;
  import sdv_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [VER_W-1:0]         frame_major;
  logic [VER_W-1:0]         frame_minor;
  logic signed [GEN_W-1:0]  frame_generation;
  logic [WORDS_W-1:0]       descriptor_words;
  logic [SIZE_W-1:0]        int_buffer_size;
  logic [SIZE_W-1:0]        float_buffer_size;
  logic [TYPE_W-1:0]        sect_code;
  logic signed [WIDE_W-1:0] num_rows;
  logic signed [WIDE_W-1:0] int_start;
  logic signed [WIDE_W-1:0] float_start;

  modport source (
    output valid, operation, frame_major, frame_minor, frame_generation,
           descriptor_words, int_buffer_size, float_buffer_size,
           sect_code, num_rows, int_start, float_start,
    input  ready
  );

  modport sink (
    input  valid, operation, frame_major, frame_minor, frame_generation,
           descriptor_words, int_buffer_size, float_buffer_size,
           sect_code, num_rows, int_start, float_start,
    output ready
  );
endinterface

interface sdv_out_if;
  import sdv_pkg::*;

  logic             valid;
  logic             ready;
  logic             frame_ok;
  logic [ERR_W-1:0] error_code;

  modport source (output valid, frame_ok, error_code, input ready);
  modport sink (input valid, frame_ok, error_code, output ready);
endinterface

[src/sdv_cfg_regs.sv]
module sdv_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sdv_pkg::PADDR_W-1:0]   paddr,
  input  logic [sdv_pkg::PDATA_W-1:0]   pwdata,
  output logic [sdv_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output sdv_pkg::cfg_t                 cfg
);
  import sdv_pkg::*;

  cfg_t                 cfg_r;
  logic [REG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.major      <= VER_W'(1);
      cfg_r.minor      <= '0;
      cfg_r.generation <= '0;
      cfg_r.mask       <= '1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_MAJOR:      cfg_r.major      <= pwdata[VER_W-1:0];
        REG_MINOR:      cfg_r.minor      <= pwdata[VER_W-1:0];
        REG_GENERATION: cfg_r.generation <= pwdata[GEN_W-1:0];
        REG_MASK:       cfg_r.mask       <= pwdata[MASK_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAJOR:      prdata = PDATA_W'(cfg_r.major);
      REG_MINOR:      prdata = PDATA_W'(cfg_r.minor);
      REG_GENERATION: prdata = PDATA_W'(cfg_r.generation);
      REG_MASK:       prdata = PDATA_W'(cfg_r.mask);
      default:        prdata = '0;
    endcase
  end

endmodule

[src/sdv_range_ram.sv]
module sdv_range_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [sdv_pkg::RANGE_AW-1:0] waddr,
  input  sdv_pkg::range_entry_t        wdata,
  input  logic                         re,
  input  logic [sdv_pkg::RANGE_AW-1:0] raddr,
  output sdv_pkg::range_entry_t        rdata
);
  import sdv_pkg::*;

  range_entry_t mem [RANGE_DEPTH];
  range_entry_t rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

[src/section_descriptor_validator.sv]
// Channel   Dir  Handshake          Carries
// in_if     in   valid/ready        header or section descriptor item
// out_if    out  valid/ready        frame verdict: frame_ok, error_code
// apb       in   psel/penable/pwr   expected version, generation, type mask
//
// One item at a time. The overlap scan of a descriptor reads the range memory
// one entry per cycle, over the N ranges already stored in the frame (0..7).
// rst_n is synchronous; the range memory needs no clearing, as only entries
// written in the current frame are read.
// The verdict waits in the output register; a new item is taken meanwhile,
// and only the next verdict stalls on out_if.ready.
module section_descriptor_validator (
  input  logic                          clk,
  input  logic                          rst_n,
  sdv_in_if.sink                        in_if,
  sdv_out_if.source                     out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sdv_pkg::PADDR_W-1:0]   paddr,
  input  logic [sdv_pkg::PDATA_W-1:0]   pwdata,
  output logic [sdv_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import sdv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_HDR, S_TYPE, S_FIT, S_SCAN, S_RESOLVE, S_FINISH, S_EMIT
  } state_t;

  cfg_t cfg;

  sdv_cfg_regs u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  state_t                  state_r;
  logic [REM_W-1:0]        remaining_r;
  err_code_t               first_error_r;
  logic [SECTION_TYPES-1:0] seen_r;
  logic [SIZE_W-1:0]       int_limit_r;
  logic [SIZE_W-1:0]       flt_limit_r;
  logic [RC_W-1:0]         range_count_r;
  logic [RANGE_AW-1:0]     scan_idx_r;
  logic                    int_hit_r;
  logic                    flt_hit_r;
  logic                    out_valid_r;
  logic                    out_ok_r;
  err_code_t               out_err_r;

  // latched item
  logic [VER_W-1:0]        q_major_r;
  logic [VER_W-1:0]        q_minor_r;
  logic [GEN_W-1:0]        q_gen_r;
  logic [WORDS_W-1:0]      q_words_r;
  logic [SIZE_W-1:0]       q_isize_r;
  logic [SIZE_W-1:0]       q_fsize_r;
  logic [TYPE_W-1:0]       q_type_r;
  logic [WIDE_W-1:0]       q_rows_r;
  logic [WIDE_W-1:0]       q_istart_r;
  logic [WIDE_W-1:0]       q_fstart_r;

  // descriptor datapath
  logic [PROD_W-1:0]       prod_i_r;
  logic [PROD_W-1:0]       prod_f_r;
  logic                    stride_zero_r;
  range_entry_t            cand_r;

  logic                    in_fire;
  logic                    out_fire;

  assign in_if.ready      = (state_r == S_IDLE);
  assign in_fire          = in_if.valid && in_if.ready;
  assign out_if.valid     = out_valid_r;
  assign out_if.frame_ok  = out_ok_r;
  assign out_if.error_code = out_err_r;
  assign out_fire         = out_valid_r && out_if.ready;

  // header decode
  logic [HP_W-1:0]    hdr_prod;
  logic [WORDS_W-1:0] hdr_count;
  logic               hdr_rem_nz;
  logic [REM_W-1:0]   hdr_count_cl;
  err_code_t          hdr_err;

  always_comb begin
    hdr_prod   = HP_W'(q_words_r) * HP_W'(RECIP);
    hdr_count  = hdr_prod[HP_W-1:RECIP_SHIFT];
    hdr_rem_nz = q_words_r != WORDS_W'(hdr_count * WORDS_W'(WORDS_PER_DESCRIPTOR));
    if (hdr_count > WORDS_W'(MAX_DESCRIPTORS)) begin
      hdr_count_cl = REM_W'(MAX_DESCRIPTORS);
    end else begin
      hdr_count_cl = REM_W'(hdr_count);
    end
    if (q_major_r != cfg.major || q_minor_r != cfg.minor) begin
      hdr_err = ERR_VERSION;
    end else if (q_gen_r != cfg.generation) begin
      hdr_err = ERR_GENERATION;
    end else if (hdr_rem_nz) begin
      hdr_err = ERR_STRIDE;
    end else begin
      hdr_err = ERR_NONE;
    end
  end

  // section type decode
  logic                  type_known;
  logic [TYPE_IDX_W-1:0] type_idx;

  assign type_known = q_type_r < TYPE_W'(SECTION_TYPES);
  assign type_idx   = q_type_r[TYPE_IDX_W-1:0];

  // bounds of the candidate ranges
  logic [SIZE_W:0] end_i;
  logic [SIZE_W:0] end_f;
  logic            fit_ok;

  always_comb begin
    end_i  = (SIZE_W+1)'(q_istart_r[SIZE_W-1:0]) + (SIZE_W+1)'(prod_i_r[SIZE_W-1:0]);
    end_f  = (SIZE_W+1)'(q_fstart_r[SIZE_W-1:0]) + (SIZE_W+1)'(prod_f_r[SIZE_W-1:0]);
    fit_ok = !q_rows_r[WIDE_W-1] && !q_istart_r[WIDE_W-1] && !q_fstart_r[WIDE_W-1] &&
             !stride_zero_r &&
             (prod_i_r[PROD_W-1:SIZE_W] == '0) && (prod_f_r[PROD_W-1:SIZE_W] == '0) &&
             (end_i <= (SIZE_W+1)'(int_limit_r)) && (end_f <= (SIZE_W+1)'(flt_limit_r));
  end

  // range memory access
  range_entry_t        rd_entry;
  logic                rd_en;
  logic [RANGE_AW-1:0] rd_addr;
  logic                scan_last;
  logic                wr_en;
  logic                int_ovl;
  logic                flt_ovl;

  assign scan_last = scan_idx_r == RANGE_AW'(range_count_r - RC_W'(1));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_idx_r + RANGE_AW'(1);
    if (state_r == S_FIT) begin
      rd_en   = fit_ok && (range_count_r != '0);
      rd_addr = '0;
    end else if (state_r == S_SCAN) begin
      rd_en   = !scan_last;
    end
  end

  assign wr_en = (state_r == S_RESOLVE) && !int_hit_r && !flt_hit_r &&
                 (range_count_r < RC_W'(RANGE_DEPTH));

  assign int_ovl = (cand_r.int_start < rd_entry.int_end) &&
                   (rd_entry.int_start < cand_r.int_end);
  assign flt_ovl = (cand_r.flt_start < rd_entry.flt_end) &&
                   (rd_entry.flt_start < cand_r.flt_end);

  sdv_range_ram u_ram (
    .clk,
    .we    (wr_en),
    .waddr (range_count_r[RANGE_AW-1:0]),
    .wdata (cand_r),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      remaining_r   <= '0;
      first_error_r <= ERR_NONE;
      seen_r        <= '0;
      int_limit_r   <= '0;
      flt_limit_r   <= '0;
      range_count_r <= '0;
      scan_idx_r    <= '0;
      int_hit_r     <= 1'b0;
      flt_hit_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      out_ok_r      <= 1'b0;
      out_err_r     <= ERR_NONE;
    end else begin
      // in emit the register is reloaded below instead
      if (out_fire && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            q_major_r  <= in_if.frame_major;
            q_minor_r  <= in_if.frame_minor;
            q_gen_r    <= in_if.frame_generation;
            q_words_r  <= in_if.descriptor_words;
            q_isize_r  <= in_if.int_buffer_size;
            q_fsize_r  <= in_if.float_buffer_size;
            q_type_r   <= in_if.sect_code;
            q_rows_r   <= in_if.num_rows;
            q_istart_r <= in_if.int_start;
            q_fstart_r <= in_if.float_start;
            if (!in_if.operation) begin
              state_r <= S_HDR;
            end else if (remaining_r == '0) begin
              state_r <= S_IDLE;  // drop: no frame open
            end else if (first_error_r != ERR_NONE) begin
              state_r <= S_FINISH;
            end else begin
              state_r <= S_TYPE;
            end
          end
        end
        S_HDR: begin
          first_error_r <= hdr_err;
          seen_r        <= '0;
          range_count_r <= '0;
          int_limit_r   <= q_isize_r;
          flt_limit_r   <= q_fsize_r;
          remaining_r   <= hdr_count_cl;
          state_r       <= (hdr_count_cl == '0) ? S_EMIT : S_IDLE;
        end
        S_TYPE: begin
          prod_i_r      <= PROD_W'(q_rows_r[SIZE_W-1:0]) * PROD_W'(int_row_step(type_idx));
          prod_f_r      <= PROD_W'(q_rows_r[SIZE_W-1:0]) * PROD_W'(flt_stride(type_idx));
          stride_zero_r <= (int_row_step(type_idx) == '0) || (flt_stride(type_idx) == '0);
          if (type_known && seen_r[type_idx]) begin
            first_error_r <= ERR_DUPLICATE;
            state_r       <= S_FINISH;
          end else begin
            if (type_known) begin
              seen_r[type_idx] <= 1'b1;
            end
            if (!type_known || !cfg.mask[type_idx]) begin
              first_error_r <= ERR_UNINSTALLED;
              state_r       <= S_FINISH;
            end else begin
              state_r <= S_FIT;
            end
          end
        end
        S_FIT: begin
          cand_r.int_start <= q_istart_r[SIZE_W-1:0];
          cand_r.int_end   <= end_i[SIZE_W-1:0];
          cand_r.flt_start <= q_fstart_r[SIZE_W-1:0];
          cand_r.flt_end   <= end_f[SIZE_W-1:0];
          int_hit_r        <= 1'b0;
          flt_hit_r        <= 1'b0;
          scan_idx_r       <= '0;
          if (!fit_ok) begin
            first_error_r <= ERR_OVERRUN;
            state_r       <= S_FINISH;
          end else if (range_count_r == '0) begin
            state_r <= S_RESOLVE;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          int_hit_r <= int_hit_r | int_ovl;
          flt_hit_r <= flt_hit_r | flt_ovl;
          if (scan_last) begin
            state_r <= S_RESOLVE;
          end else begin
            scan_idx_r <= scan_idx_r + RANGE_AW'(1);
          end
        end
        S_RESOLVE: begin
          // any integer overlap outranks a float overlap
          if (int_hit_r) begin
            first_error_r <= ERR_INT_OVERLAP;
          end else if (flt_hit_r) begin
            first_error_r <= ERR_FLT_OVERLAP;
          end else if (wr_en) begin
            range_count_r <= range_count_r + RC_W'(1);
          end
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          remaining_r <= remaining_r - REM_W'(1);
          state_r     <= (remaining_r == REM_W'(1)) ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          // hold until the previous verdict has left
          if (!out_valid_r || out_if.ready) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= (first_error_r == ERR_NONE);
            out_err_r   <= first_error_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_range_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    range_count_r <= RC_W'(RANGE_DEPTH))
    else $error("range count beyond memory depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> RC_W'(scan_idx_r) < range_count_r)
    else $error("scan index past stored ranges");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_HDR && first_error_r != ERR_NONE) |=> first_error_r == $past(first_error_r))
    else $error("latched error changed within a frame");

  a_verdict_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == S_EMIT))
    else $error("verdict raised outside emit");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import sdv_pkg::*;

  typedef struct packed {
    logic                op;
    logic [VER_W-1:0]    major;
    logic [VER_W-1:0]    minor;
    logic [GEN_W-1:0]    gen;
    logic [WORDS_W-1:0]  words;
    logic [SIZE_W-1:0]   int_size;
    logic [SIZE_W-1:0]   flt_size;
    logic [TYPE_W-1:0]   stype;
    logic [WIDE_W-1:0]   rows;
    logic [WIDE_W-1:0]   int_at;
    logic [WIDE_W-1:0]   flt_at;
  } frame_item_t;

  typedef struct packed {
    logic      ok;
    err_code_t code;
  } verdict_t;

  localparam logic OP_HEADER     = 1'b0;
  localparam logic OP_DESCRIPTOR = 1'b1;

  // per-type row strides, type 6 in the top slot
  localparam logic [20:0] INT_STEPS = {3'd4, 3'd4, 3'd5, 3'd3, 3'd3, 3'd3, 3'd4};
  localparam logic [20:0] FLT_STEPS = {3'd2, 3'd3, 3'd1, 3'd3, 3'd4, 3'd5, 3'd2};

  logic clk;
  logic rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  sdv_in_if  in_if ();
  sdv_out_if out_if ();

  section_descriptor_validator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // installed schema as seen by the checker
  logic [VER_W-1:0]  cfg_major;
  logic [VER_W-1:0]  cfg_minor;
  logic [GEN_W-1:0]  cfg_gen;
  logic [MASK_W-1:0] cfg_mask;

  // frame state of the checker
  int unsigned        frame_left;
  err_code_t          frame_err;
  logic [6:0]         types_seen;
  longint             int_cap;
  longint             flt_cap;
  int                 span_count;
  longint             int_lo [0:6];
  longint             int_hi [0:6];
  longint             flt_lo [0:6];
  longint             flt_hi [0:6];

  frame_item_t pending [$];
  verdict_t    verdicts_due [$];
  int          mismatches;
  bit          in_took;

  int          burst_max;
  int          gap_max;
  int          burst_left;
  int          gap_left;
  int          stall_mode;
  logic [15:0] rx_pattern;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.operation = 1'b0;
    in_if.frame_major = '0;
    in_if.frame_minor = '0;
    in_if.frame_generation = '0;
    in_if.descriptor_words = '0;
    in_if.int_buffer_size = '0;
    in_if.float_buffer_size = '0;
    in_if.sect_code = '0;
    in_if.num_rows = '0;
    in_if.int_start = '0;
    in_if.float_start = '0;
    out_if.ready = 1'b0;
    in_took = 1'b0;
    mismatches = 0;
    burst_max = 4;
    gap_max = 3;
    burst_left = 0;
    gap_left = 0;
    stall_mode = 1;
    rx_pattern = 16'hA5C3;
    cfg_major = 8'd1;
    cfg_minor = 8'd0;
    cfg_gen = '0;
    cfg_mask = 7'h7F;
    frame_left = 0;
    frame_err = ERR_NONE;
    types_seen = '0;
    int_cap = 0;
    flt_cap = 0;
    span_count = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic bit span_fits(longint start, longint rows, longint stride,
                                   longint limit, output longint stop);
    longint prod;
    stop = 0;
    if (start < 0 || rows < 0 || stride <= 0)
      return 1'b0;
    prod = rows * stride;
    if (prod > 64'sd2147483647)
      return 1'b0;
    stop = start + prod;
    return stop <= limit;
  endfunction

  task automatic judge_descriptor(input frame_item_t it);
    int     t;
    longint rows;
    longint is;
    longint fs;
    longint ie;
    longint fe;
    t = int'(it.stype);
    rows = longint'($signed(it.rows));
    is = longint'($signed(it.int_at));
    fs = longint'($signed(it.flt_at));
    if (t < 7 && types_seen[t]) begin
      frame_err = ERR_DUPLICATE;
      return;
    end
    if (t < 7)
      types_seen[t] = 1'b1;
    if (t >= 7 || !cfg_mask[t]) begin
      frame_err = ERR_UNINSTALLED;
      return;
    end
    if (!span_fits(is, rows, longint'(INT_STEPS[t*3 +: 3]), int_cap, ie) ||
        !span_fits(fs, rows, longint'(FLT_STEPS[t*3 +: 3]), flt_cap, fe)) begin
      frame_err = ERR_OVERRUN;
      return;
    end
    for (int i = 0; i < span_count; i++) begin
      if (is < int_hi[i] && int_lo[i] < ie) begin
        frame_err = ERR_INT_OVERLAP;
        return;
      end
    end
    for (int i = 0; i < span_count; i++) begin
      if (fs < flt_hi[i] && flt_lo[i] < fe) begin
        frame_err = ERR_FLT_OVERLAP;
        return;
      end
    end
    if (span_count < 7) begin
      int_lo[span_count] = is;
      int_hi[span_count] = ie;
      flt_lo[span_count] = fs;
      flt_hi[span_count] = fe;
      span_count++;
    end
  endtask

  task automatic judge_item(input frame_item_t it, output bit fires, output verdict_t v);
    int unsigned count;
    fires = 1'b0;
    v = '0;
    if (it.op == OP_HEADER) begin
      frame_err = ERR_NONE;
      types_seen = '0;
      span_count = 0;
      int_cap = longint'(it.int_size);
      flt_cap = longint'(it.flt_size);
      if (it.major != cfg_major || it.minor != cfg_minor)
        frame_err = ERR_VERSION;
      else if (it.gen != cfg_gen)
        frame_err = ERR_GENERATION;
      else if (it.words % WORDS_PER_DESCRIPTOR != 0)
        frame_err = ERR_STRIDE;
      count = it.words / WORDS_PER_DESCRIPTOR;
      if (count > MAX_DESCRIPTORS)
        count = MAX_DESCRIPTORS;
      frame_left = count;
      if (frame_left != 0)
        return;
    end else begin
      // drop descriptors outside a frame
      if (frame_left == 0)
        return;
      if (frame_err == ERR_NONE)
        judge_descriptor(it);
      frame_left--;
      if (frame_left != 0)
        return;
    end
    fires = 1'b1;
    v.ok = (frame_err == ERR_NONE);
    v.code = frame_err;
  endtask

  always @(posedge clk) begin : watch
    frame_item_t seen;
    verdict_t    want;
    bit          fires;
    verdict_t    v;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: verdict with none expected, got ok=%0d code=%0d",
                 $time, out_if.frame_ok, out_if.error_code);
        mismatches++;
      end else begin
        want = verdicts_due.pop_front();
        if (out_if.frame_ok !== want.ok) begin
          $display("%0t: frame_ok expected %0d got %0d", $time, want.ok, out_if.frame_ok);
          mismatches++;
        end
        if (out_if.error_code !== want.code) begin
          $display("%0t: error_code expected %0d got %0d",
                   $time, want.code, out_if.error_code);
          mismatches++;
        end
      end
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      seen.op = in_if.operation;
      seen.major = in_if.frame_major;
      seen.minor = in_if.frame_minor;
      seen.gen = in_if.frame_generation;
      seen.words = in_if.descriptor_words;
      seen.int_size = in_if.int_buffer_size;
      seen.flt_size = in_if.float_buffer_size;
      seen.stype = in_if.sect_code;
      seen.rows = in_if.num_rows;
      seen.int_at = in_if.int_start;
      seen.flt_at = in_if.float_start;
      judge_item(seen, fires, v);
      if (fires)
        verdicts_due.insert(verdicts_due.size(), v);
      in_took = 1'b1;
    end
  end

  always @(negedge clk) begin : drive
    frame_item_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_took) begin
      // hold until taken
    end else begin
      in_took = 1'b0;
      if (gap_left > 0 || pending.size() == 0) begin
        if (gap_left > 0)
          gap_left--;
        in_if.valid <= 1'b0;
      end else begin
        nxt = pending.pop_front();
        in_if.operation <= nxt.op;
        in_if.frame_major <= nxt.major;
        in_if.frame_minor <= nxt.minor;
        in_if.frame_generation <= nxt.gen;
        in_if.descriptor_words <= nxt.words;
        in_if.int_buffer_size <= nxt.int_size;
        in_if.float_buffer_size <= nxt.flt_size;
        in_if.sect_code <= nxt.stype;
        in_if.num_rows <= nxt.rows;
        in_if.int_start <= nxt.int_at;
        in_if.float_start <= nxt.flt_at;
        in_if.valid <= 1'b1;
        if (burst_left > 0)
          burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, burst_max);
          gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        end
      end
    end
  end

  always @(negedge clk) begin
    rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
    if ($urandom_range(0, 63) == 0)
      rx_pattern = 16'($urandom);
    if (stall_mode == 0)
      out_if.ready <= 1'b1;
    else if (stall_mode == 1)
      out_if.ready <= rx_pattern[0] | rx_pattern[5];
    else
      out_if.ready <= rx_pattern[0] & rx_pattern[3];
  end

  function automatic frame_item_t make_header(logic [7:0] major, logic [7:0] minor,
                                              logic [31:0] gen, logic [12:0] words,
                                              logic [30:0] isz, logic [30:0] fsz);
    frame_item_t it;
    it.op = OP_HEADER;
    it.major = major;
    it.minor = minor;
    it.gen = gen;
    it.words = words;
    it.int_size = isz;
    it.flt_size = fsz;
    it.stype = 8'($urandom);
    it.rows = $urandom;
    it.int_at = $urandom;
    it.flt_at = $urandom;
    return it;
  endfunction

  function automatic frame_item_t make_descriptor(logic [7:0] stype, logic [31:0] rows,
                                                  logic [31:0] is, logic [31:0] fs);
    frame_item_t it;
    it.op = OP_DESCRIPTOR;
    it.major = 8'($urandom);
    it.minor = 8'($urandom);
    it.gen = $urandom;
    it.words = 13'($urandom);
    it.int_size = 31'($urandom);
    it.flt_size = 31'($urandom);
    it.stype = stype;
    it.rows = rows;
    it.int_at = is;
    it.flt_at = fs;
    return it;
  endfunction

  task automatic queue_item(input frame_item_t it);
    pending.insert(pending.size(), it);
  endtask

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_MAJOR:      cfg_major = value[7:0];
      REG_MINOR:      cfg_minor = value[7:0];
      REG_GENERATION: cfg_gen = value;
      REG_MASK:       cfg_mask = value[6:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_check(input logic [REG_IDX_W-1:0] idx, input logic [31:0] want);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $display("%0t: register %0d read expected %h got %h", $time, idx, want, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_schema();
    apb_check(REG_MAJOR, {24'd0, cfg_major});
    apb_check(REG_MINOR, {24'd0, cfg_minor});
    apb_check(REG_GENERATION, cfg_gen);
    apb_check(REG_MASK, {25'd0, cfg_mask});
  endtask

  task automatic install_schema(input logic [7:0] major, input logic [7:0] minor,
                                input logic [31:0] gen, input logic [6:0] mask);
    apb_write(REG_MAJOR, {24'd0, major});
    apb_write(REG_MINOR, {24'd0, minor});
    apb_write(REG_GENERATION, gen);
    apb_write(REG_MASK, {25'd0, mask});
    check_schema();
  endtask

  // wait for the block to go quiet before touching registers
  task automatic drain();
    while (pending.size() > 0 || in_if.valid) @(negedge clk);
    while (verdicts_due.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic push_directed();
    queue_item(make_header(8'd2, 8'd0, 32'd0, 13'd0, 31'd10, 31'd10));
    queue_item(make_descriptor(8'd0, 32'd1, 32'd0, 32'd0));
    queue_item(make_header(8'd1, 8'd0, 32'hFFFF_FFFF, 13'd0, 31'd10, 31'd10));
    // version failure still consumes its descriptor
    queue_item(make_header(8'd1, 8'd255, 32'd0, 13'd5, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
    queue_item(make_descriptor(8'd3, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0));
    // all seven types, the first one empty at offset 0
    queue_item(make_header(8'd1, 8'd0, 32'd0, 13'd35, 31'd1000, 31'd1000));
    for (int t = 0; t < 7; t++)
      queue_item(make_descriptor(8'(t), (t == 0) ? 32'd0 : 32'd5,
                                 (t == 0) ? 32'd0 : 32'(15 * (t - 1)),
                                 (t == 0) ? 32'd0 : 32'(25 * (t - 1))));
    queue_item(make_header(8'd1, 8'd0, 32'd0, 13'd10, 31'd100, 31'd100));
    queue_item(make_descriptor(8'd2, 32'd1, 32'd0, 32'd0));
    queue_item(make_descriptor(8'd2, 32'd1, 32'd10, 32'd10));
    queue_item(make_header(8'd1, 8'd0, 32'd0, 13'd5, 31'd100, 31'd100));
    queue_item(make_descriptor(8'd255, 32'd1, 32'd0, 32'd0));
    queue_item(make_header(8'd1, 8'd0, 32'd0, 13'd5, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
    queue_item(make_descriptor(8'd4, 32'h7FFF_FFFF, 32'd0, 32'd0));
    queue_item(make_header(8'd1, 8'd0, 32'd0, 13'd10, 31'd1000, 31'd1000));
    queue_item(make_descriptor(8'd0, 32'd10, 32'd0, 32'd0));
    queue_item(make_descriptor(8'd1, 32'd1, 32'd39, 32'd20));
    queue_item(make_header(8'd1, 8'd0, 32'd0, 13'd10, 31'd1000, 31'd1000));
    queue_item(make_descriptor(8'd0, 32'd10, 32'd0, 32'd0));
    queue_item(make_descriptor(8'd1, 32'd1, 32'd40, 32'd19));
    // abandon a frame with a fresh header
    queue_item(make_header(8'd1, 8'd0, 32'd0, 13'd15, 31'd100, 31'd100));
    queue_item(make_descriptor(8'd3, 32'd1, 32'd0, 32'd0));
    queue_item(make_header(8'd1, 8'd0, 32'd0, 13'd3, 31'd100, 31'd100));
  endtask

  task automatic push_frame(output int counted);
    frame_item_t descs [0:11];
    int          order [0:6];
    int          n;
    int          npush;
    int          j;
    int          tmp;
    int          r;
    int          si;
    int          sf;
    logic [7:0]  stype;
    longint      icur;
    longint      fcur;
    longint      rows;
    longint      is;
    longint      fs;
    logic [7:0]  major;
    logic [7:0]  minor;
    logic [31:0] gen;
    logic [12:0] words;
    logic [30:0] isz;
    logic [30:0] fsz;
    counted = 0;
    if ($urandom_range(0, 99) < 4) begin
      queue_item(make_descriptor(8'($urandom), $urandom, $urandom, $urandom));
      return;
    end
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 7);
    for (int k = 0; k < 7; k++)
      order[k] = k;
    for (int k = 6; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    icur = ($urandom_range(0, 19) == 0) ? longint'($urandom_range(0, 1 << 30))
                                        : longint'($urandom_range(0, 20));
    fcur = ($urandom_range(0, 19) == 0) ? longint'($urandom_range(0, 1 << 30))
                                        : longint'($urandom_range(0, 20));
    for (int k = 0; k < n; k++) begin
      stype = 8'(order[k % 7]);
      r = $urandom_range(0, 99);
      if (r < 5)
        stype = 8'($urandom_range(0, 255));
      else if (r < 10 && k > 0)
        stype = descs[$urandom_range(0, k - 1)].stype;
      r = $urandom_range(0, 99);
      if (r < 75)
        rows = longint'($urandom_range(0, 40));
      else if (r < 82)
        rows = 0;
      else if (r < 88)
        rows = -longint'($urandom_range(1, 1000));
      else if (r < 94)
        rows = longint'($urandom_range(1 << 28, 32'h7FFF_FFFF));
      else
        rows = longint'($signed($urandom));
      si = (stype < 7) ? int'(INT_STEPS[stype*3 +: 3]) : 1;
      sf = (stype < 7) ? int'(FLT_STEPS[stype*3 +: 3]) : 1;
      is = icur + longint'($urandom_range(0, 3));
      r = $urandom_range(0, 99);
      if (r < 6 && k > 0)
        is = icur - longint'($urandom_range(1, 8));
      else if (r < 9)
        is = longint'($signed($urandom));
      fs = fcur + longint'($urandom_range(0, 3));
      r = $urandom_range(0, 99);
      if (r < 6 && k > 0)
        fs = fcur - longint'($urandom_range(1, 8));
      else if (r < 9)
        fs = longint'($signed($urandom));
      descs[k] = make_descriptor(stype, rows[31:0], is[31:0], fs[31:0]);
      if (rows >= 0 && rows < (1 << 20)) begin
        if (is >= 0 && is < (1 << 30) && is + rows * si > icur)
          icur = is + rows * si;
        if (fs >= 0 && fs < (1 << 30) && fs + rows * sf > fcur)
          fcur = fs + rows * sf;
      end
    end
    r = $urandom_range(0, 99);
    if (r < 80)
      isz = 31'(icur + longint'($urandom_range(0, 6)));
    else if (r < 88)
      isz = (icur > 0) ? 31'(icur - 1) : 31'd0;
    else
      isz = 31'($urandom);
    r = $urandom_range(0, 99);
    if (r < 80)
      fsz = 31'(fcur + longint'($urandom_range(0, 6)));
    else if (r < 88)
      fsz = (fcur > 0) ? 31'(fcur - 1) : 31'd0;
    else
      fsz = 31'($urandom);
    major = ($urandom_range(0, 99) < 5) ? 8'($urandom) : cfg_major;
    minor = ($urandom_range(0, 99) < 4) ? 8'($urandom) : cfg_minor;
    r = $urandom_range(0, 99);
    if (r < 5)
      gen = cfg_gen ^ (32'd1 << $urandom_range(0, 31));
    else if (r < 7)
      gen = $urandom;
    else
      gen = cfg_gen;
    npush = n;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      words = 13'(n * 5 + int'($urandom_range(1, 4)));
    end else if (r < 13) begin
      // cut the frame short, the next header abandons it
      words = 13'($urandom_range(0, 8191));
      npush = $urandom_range(0, (n < 3) ? n : 3);
    end else begin
      words = 13'(n * 5);
    end
    queue_item(make_header(major, minor, gen, words, isz, fsz));
    for (int k = 0; k < npush; k++)
      queue_item(descs[k]);
    counted = 1 + npush;
  endtask

  task automatic run_phase(input logic [7:0] major, input logic [7:0] minor,
                           input logic [31:0] gen, input logic [6:0] mask,
                           input int bmax, input int gmax, input int stall);
    int sent;
    int got;
    install_schema(major, minor, gen, mask);
    burst_max = bmax;
    gap_max = gmax;
    stall_mode = stall;
    sent = 0;
    while (sent < 70) begin
      push_frame(got);
      sent += got;
    end
    drain();
  endtask

  initial begin : control
    while (rst_n !== 1'b1) @(negedge clk);
    check_schema();
    push_directed();
    drain();
    run_phase(8'd255, 8'd255, 32'h7FFF_FFFF, 7'h7F, 8, 0, 0);
    run_phase(8'd0, 8'd0, 32'h8000_0000, 7'h00, 3, 6, 2);
    run_phase(8'($urandom), 8'($urandom), $urandom, 7'($urandom), 6, 2, 1);
    run_phase(8'($urandom), 8'($urandom), $urandom, 7'h7F, 1, 4, 1);
    run_phase(8'd1, 8'd0, 32'd0, 7'($urandom), 10, 1, 0);
    // oversized word count, cut short by the next header
    burst_max = 16;
    gap_max = 2;
    stall_mode = 1;
    queue_item(make_header(cfg_major, cfg_minor, cfg_gen, 13'd8190,
                           31'h7FFF_FFFF, 31'h7FFF_FFFF));
    for (int k = 0; k < 3; k++)
      queue_item(make_descriptor(8'(k), 32'd1, 32'(8 * k), 32'(8 * k)));
    queue_item(make_header(cfg_major, cfg_minor, cfg_gen, 13'd0, 31'd0, 31'd0));
    drain();
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
